// ----- hw/rtl/u8wd_pkg.sv -----
// Package for the UTF-8 window decoder.
// Holds the result record type and sequence-length constants.
// No dependencies.
package u8wd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CP_W      = 16;
    localparam int unsigned USED_W    = 3;

    // Bytes consumed for each sequence length, and for a rejected sequence
    localparam logic [USED_W-1:0] USED_LEN1  = 3'd1;
    localparam logic [USED_W-1:0] USED_LEN2  = 3'd2;
    localparam logic [USED_W-1:0] USED_LEN3  = 3'd3;
    localparam logic [USED_W-1:0] USED_LEN4  = 3'd4;
    localparam logic [USED_W-1:0] USED_LEN5  = 3'd5;
    localparam logic [USED_W-1:0] USED_LEN6  = 3'd6;
    localparam logic [USED_W-1:0] USED_ERROR = 3'd2;

    localparam logic [CP_W-1:0] CP_ERROR = 16'h0000;

    // Continuation byte tag (10xxxxxx)
    localparam logic [1:0] CONT_TAG = 2'b10;

    typedef struct packed {
        logic [CP_W-1:0]   code_point;
        logic [USED_W-1:0] bytes_used;
        logic              bad_sequence;
    } u8wd_result_t;

endpackage

// ----- hw/rtl/u8wd_decode.sv -----
// Combinational decode of one six-byte window into a code point.
// Depends on u8wd_pkg for the result record and length constants.
module u8wd_decode
    import u8wd_pkg::*;
(
    input  logic [BYTE_W-1:0] lead_byte,
    input  logic [BYTE_W-1:0] second_byte,
    input  logic [BYTE_W-1:0] third_byte,
    input  logic [BYTE_W-1:0] fourth_byte,
    input  logic [BYTE_W-1:0] fifth_byte,
    input  logic [BYTE_W-1:0] sixth_byte,
    output u8wd_result_t      result
);

    logic c1;
    logic c2;
    logic c3;
    logic c4;
    logic c5;

    assign c1 = (second_byte[7:6] == CONT_TAG);
    assign c2 = (third_byte[7:6]  == CONT_TAG);
    assign c3 = (fourth_byte[7:6] == CONT_TAG);
    assign c4 = (fifth_byte[7:6]  == CONT_TAG);
    assign c5 = (sixth_byte[7:6]  == CONT_TAG);

    // Overlong check: the payload bits above the next shorter form must not all be zero.
    // Wide values keep only their low 16 bits.
    always_comb
    begin
        result.code_point   = CP_ERROR;
        result.bytes_used   = USED_ERROR;
        result.bad_sequence = 1'b1;
        priority if (lead_byte[7] == 1'b0)
        begin
            result.code_point   = {{(CP_W-BYTE_W){1'b0}}, lead_byte};
            result.bytes_used   = USED_LEN1;
            result.bad_sequence = 1'b0;
        end
        else if (lead_byte[7:5] == 3'b110)
        begin
            if (c1 && (lead_byte[4:1] != 4'd0))
            begin
                result.code_point   = {5'd0, lead_byte[4:0], second_byte[5:0]};
                result.bytes_used   = USED_LEN2;
                result.bad_sequence = 1'b0;
            end
        end
        else if (lead_byte[7:4] == 4'b1110)
        begin
            if (c1 && c2 && ((lead_byte[3:0] != 4'd0) || second_byte[5]))
            begin
                result.code_point   = {lead_byte[3:0], second_byte[5:0], third_byte[5:0]};
                result.bytes_used   = USED_LEN3;
                result.bad_sequence = 1'b0;
            end
        end
        else if (lead_byte[7:3] == 5'b11110)
        begin
            if (c1 && c2 && c3 && ((lead_byte[2:0] != 3'd0) || (second_byte[5:4] != 2'd0)))
            begin
                result.code_point   = {second_byte[3:0], third_byte[5:0], fourth_byte[5:0]};
                result.bytes_used   = USED_LEN4;
                result.bad_sequence = 1'b0;
            end
        end
        else if (lead_byte[7:2] == 6'b111110)
        begin
            if (c1 && c2 && c3 && c4 &&
                ((lead_byte[1:0] != 2'd0) || (second_byte[5:3] != 3'd0)))
            begin
                result.code_point   = {third_byte[3:0], fourth_byte[5:0], fifth_byte[5:0]};
                result.bytes_used   = USED_LEN5;
                result.bad_sequence = 1'b0;
            end
        end
        else if (lead_byte[7:1] == 7'b1111110)
        begin
            if (c1 && c2 && c3 && c4 && c5 &&
                (lead_byte[0] || (second_byte[5:2] != 4'd0)))
            begin
                result.code_point   = {fourth_byte[3:0], fifth_byte[5:0], sixth_byte[5:0]};
                result.bytes_used   = USED_LEN6;
                result.bad_sequence = 1'b0;
            end
        end
        else
        begin
            // stray continuation byte or 0xFE/0xFF as lead: keep the error result
            result.bad_sequence = 1'b1;
        end
    end

endmodule

// ----- hw/rtl/utf8_window_decoder.sv -----
// UTF-8 window decoder, top level: input register, decode, result register.
// Depends on u8wd_pkg and u8wd_decode.
//
// Usage:
//   The input channel (in_valid/in_ready) carries a window of six bytes that
//   starts at a character. The output channel (out_valid/out_ready) returns
//   one result per window: code_point (low 16 bits of the value, 0 on error),
//   bytes_used (1 to 6, or 2 on error) and bad_sequence.
//   After an input transfer the window sits in the input register; the result
//   register then loads its decode and out_valid rises with it.
//   Throughput is one window per cycle while out_ready stays high; it is set
//   by the two-entry register pipeline, each stage loading whenever the stage
//   after it is empty or draining.
//   When the receiver stalls, the result register holds its value and the
//   input register can still take one more window; after that in_ready drops.
//   Reset clears both stage valid bits; no results are pending after reset.
module utf8_window_decoder
    import u8wd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] lead_byte,
    input  logic [BYTE_W-1:0] second_byte,
    input  logic [BYTE_W-1:0] third_byte,
    input  logic [BYTE_W-1:0] fourth_byte,
    input  logic [BYTE_W-1:0] fifth_byte,
    input  logic [BYTE_W-1:0] sixth_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CP_W-1:0]   code_point,
    output logic [USED_W-1:0] bytes_used,
    output logic              bad_sequence
);

    logic              win_valid_reg;
    logic [BYTE_W-1:0] b0_reg;
    logic [BYTE_W-1:0] b1_reg;
    logic [BYTE_W-1:0] b2_reg;
    logic [BYTE_W-1:0] b3_reg;
    logic [BYTE_W-1:0] b4_reg;
    logic [BYTE_W-1:0] b5_reg;

    logic              res_valid_reg;
    u8wd_result_t      res_reg;
    u8wd_result_t      res_next;

    logic              res_load;
    logic              win_load;

    // Advance the result stage when it is empty or its transfer completes.
    assign res_load = !res_valid_reg || out_ready;
    assign in_ready = !win_valid_reg || res_load;
    assign win_load = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                win_valid_reg <= in_valid;
            end
            if (res_load)
            begin
                res_valid_reg <= win_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_load)
        begin
            b0_reg <= lead_byte;
            b1_reg <= second_byte;
            b2_reg <= third_byte;
            b3_reg <= fourth_byte;
            b4_reg <= fifth_byte;
            b5_reg <= sixth_byte;
        end
        if (res_load && win_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    u8wd_decode u_decode (
        .lead_byte   (b0_reg),
        .second_byte (b1_reg),
        .third_byte  (b2_reg),
        .fourth_byte (b3_reg),
        .fifth_byte  (b4_reg),
        .sixth_byte  (b5_reg),
        .result      (res_next)
    );

    assign out_valid    = res_valid_reg;
    assign code_point   = res_reg.code_point;
    assign bytes_used   = res_reg.bytes_used;
    assign bad_sequence = res_reg.bad_sequence;

    // A window held back by a stalled result stage must not be dropped.
    a_win_held : assert property (@(posedge clk) disable iff (!rst_n)
        (win_valid_reg && !res_load) |=> win_valid_reg)
        else $error("window lost while result stage stalled");

    a_err_shape : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_sequence) |-> (code_point == CP_ERROR && bytes_used == USED_ERROR))
        else $error("error result has wrong shape");

    a_used_range : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !bad_sequence) |-> (bytes_used != 3'd0 && bytes_used != 3'd7))
        else $error("bytes_used out of range");

    a_ascii : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !bad_sequence && bytes_used == USED_LEN1) |-> (code_point[15:7] == 9'd0))
        else $error("single-byte result above 127");

    a_two_byte : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !bad_sequence && bytes_used == USED_LEN2)
            |-> (code_point[15:11] == 5'd0 && code_point[10:7] != 4'd0))
        else $error("two-byte result overlong or too wide");

endmodule

// ----- test/tb_utf8_window_decoder.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for utf8_window_decoder: directed windows, then random ones.
// Depends on u8wd_pkg and the utf8_window_decoder RTL.
module tb_utf8_window_decoder;
    import u8wd_pkg::*;

    localparam int RANDOM_WINDOWS = 1150;
    localparam int QUIET_TAIL     = 150;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int DRAIN_CYCLES   = 4;

    typedef struct {
        logic [47:0]  window;
        bit           known;
        u8wd_result_t result;
    } dir_row_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [BYTE_W-1:0] lead_byte;
    logic [BYTE_W-1:0] second_byte;
    logic [BYTE_W-1:0] third_byte;
    logic [BYTE_W-1:0] fourth_byte;
    logic [BYTE_W-1:0] fifth_byte;
    logic [BYTE_W-1:0] sixth_byte;
    logic              out_valid;
    logic              out_ready;
    logic [CP_W-1:0]   code_point;
    logic [USED_W-1:0] bytes_used;
    logic              bad_sequence;

    u8wd_result_t pending_chars[$];
    dir_row_t     dir_rows[$];
    bit           idle_on;
    int           mismatches;
    int           windows_sent;
    int           chars_checked;
    int           rejects_expected;
    int           idle_cycles;
    bit [6:1]     lengths_seen;

    utf8_window_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .lead_byte    (lead_byte),
        .second_byte  (second_byte),
        .third_byte   (third_byte),
        .fourth_byte  (fourth_byte),
        .fifth_byte   (fifth_byte),
        .sixth_byte   (sixth_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .code_point   (code_point),
        .bytes_used   (bytes_used),
        .bad_sequence (bad_sequence)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Byte 0 is the lead byte, held in the top eight bits of the window
    function automatic logic [7:0] byte_at(input logic [47:0] w, input int k);
        return w[47-8*k -: 8];
    endfunction

    function automatic u8wd_result_t decode_window(input logic [47:0] w);
        u8wd_result_t      r;
        logic [7:0]        lead;
        logic [7:0]        b;
        logic [USED_W-1:0] used;
        logic [63:0]       acc;
        logic [63:0]       vmask;
        logic [63:0]       vmin;
        int                len;
        bit                cont_ok;
        lead = byte_at(w, 0);
        r.code_point   = CP_ERROR;
        r.bytes_used   = USED_ERROR;
        r.bad_sequence = 1'b1;
        len = 0;
        used = USED_ERROR;
        if (!lead[7])
        begin
            r.code_point   = {8'h00, lead};
            r.bytes_used   = USED_LEN1;
            r.bad_sequence = 1'b0;
            return r;
        end
        else if (lead[7:5] == 3'b110)
        begin
            len = 2;
            used = USED_LEN2;
        end
        else if (lead[7:4] == 4'b1110)
        begin
            len = 3;
            used = USED_LEN3;
        end
        else if (lead[7:3] == 5'b11110)
        begin
            len = 4;
            used = USED_LEN4;
        end
        else if (lead[7:2] == 6'b111110)
        begin
            len = 5;
            used = USED_LEN5;
        end
        else if (lead[7:1] == 7'b1111110)
        begin
            len = 6;
            used = USED_LEN6;
        end
        // continuation byte or 0xFE/0xFF as lead
        if (len == 0)
            return r;
        acc = {56'd0, lead};
        cont_ok = 1'b1;
        for (int k = 1; k < len; k++)
        begin
            b = byte_at(w, k);
            if (b[7:6] != CONT_TAG)
                cont_ok = 1'b0;
            acc = (acc << 6) | {58'd0, b[5:0]};
        end
        // a length-n form carries 5n+1 payload bits; its smallest legal value is one above the
        // largest value of the next shorter form: 2^(5n-4) for three bytes and up, 2^7 for two bytes
        vmask = (64'd1 << (5*len + 1)) - 64'd1;
        vmin  = (len == 2) ? 64'h80 : (64'd1 << (5*len - 4));
        acc = acc & vmask;
        if (!cont_ok || acc < vmin)
            return r;
        r.code_point   = acc[15:0];
        r.bytes_used   = used;
        r.bad_sequence = 1'b0;
        return r;
    endfunction

    function automatic logic [47:0] make_window();
        logic [47:0] w;
        logic [7:0]  lead;
        logic [7:0]  b;
        int          len;
        int          mode;
        int          k;
        w = {$urandom(), 16'($urandom())};
        mode = $urandom_range(0, 9);
        if (mode == 0)
            return w;
        len = $urandom_range(1, 6);
        lead = byte_at(w, 0);
        // clear payload now and then to land near the overlong boundary
        if ($urandom_range(0, 3) == 0)
            lead = 8'h00;
        case (len)
            1: lead[7]   = 1'b0;
            2: lead[7:5] = 3'b110;
            3: lead[7:4] = 4'b1110;
            4: lead[7:3] = 5'b11110;
            5: lead[7:2] = 6'b111110;
            default: lead[7:1] = 7'b1111110;
        endcase
        if (mode == 1)
            lead = ($urandom_range(0, 3) == 0) ? {7'b1111111, 1'($urandom)}
                                               : {CONT_TAG, 6'($urandom)};
        w[47 -: 8] = lead;
        for (k = 1; k < len; k++)
            w[47-8*k -: 8] = {CONT_TAG, 6'($urandom)};
        if (mode == 2 && len > 1)
        begin
            k = $urandom_range(1, len - 1);
            b = byte_at(w, k);
            case ($urandom_range(0, 2))
                0: b[7:6] = 2'b00;
                1: b[7:6] = 2'b01;
                default: b[7:6] = 2'b11;
            endcase
            w[47-8*k -: 8] = b;
        end
        return w;
    endfunction

    task automatic add_row(input logic [47:0] w, input bit known, input logic [CP_W-1:0] cp,
                           input logic [USED_W-1:0] used, input logic bad);
        dir_row_t row;
        row.window = w;
        row.known = known;
        row.result.code_point = cp;
        row.result.bytes_used = used;
        row.result.bad_sequence = bad;
        dir_rows.push_back(row);
    endtask

    task automatic send_window(input logic [47:0] w, input u8wd_result_t want);
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        lead_byte   <= byte_at(w, 0);
        second_byte <= byte_at(w, 1);
        third_byte  <= byte_at(w, 2);
        fourth_byte <= byte_at(w, 3);
        fifth_byte  <= byte_at(w, 4);
        sixth_byte  <= byte_at(w, 5);
        do
            @(posedge clk);
        while (!in_ready);
        pending_chars.push_back(want);
        windows_sent++;
        if (want.bad_sequence)
            rejects_expected++;
        else
            lengths_seen[want.bytes_used] = 1'b1;
    endtask

    // Hold the sender off until every expected character has come back
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        logic [47:0]  w;
        u8wd_result_t want;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        lead_byte   <= '0;
        second_byte <= '0;
        third_byte  <= '0;
        fourth_byte <= '0;
        fifth_byte  <= '0;
        sixth_byte  <= '0;
        idle_on     = 1'b1;
        mismatches = 0;
        windows_sent = 0;
        chars_checked = 0;
        rejects_expected = 0;
        lengths_seen = '0;

        // single bytes, bad leads
        add_row(48'h00_00_00_00_00_00, 1, 16'h0000, USED_LEN1, 1'b0);
        add_row(48'h7F_FF_FF_FF_FF_FF, 1, 16'h007F, USED_LEN1, 1'b0);
        add_row(48'h41_FF_FF_FF_FF_FF, 1, 16'h0041, USED_LEN1, 1'b0);
        add_row(48'h80_80_80_80_80_80, 1, CP_ERROR, USED_ERROR, 1'b1);
        add_row(48'hBF_BF_BF_BF_BF_BF, 1, CP_ERROR, USED_ERROR, 1'b1);
        add_row(48'hFE_80_80_80_80_80, 1, CP_ERROR, USED_ERROR, 1'b1);
        add_row(48'hFF_BF_BF_BF_BF_BF, 1, CP_ERROR, USED_ERROR, 1'b1);
        // two bytes: overlong, bounds, trailing junk
        add_row(48'hC0_80_00_00_00_00, 1, CP_ERROR, USED_ERROR, 1'b1);
        add_row(48'hC1_BF_00_00_00_00, 1, CP_ERROR, USED_ERROR, 1'b1);
        add_row(48'hC2_80_00_00_00_00, 1, 16'h0080, USED_LEN2, 1'b0);
        add_row(48'hDF_BF_00_00_00_00, 1, 16'h07FF, USED_LEN2, 1'b0);
        add_row(48'hC2_A9_FF_FF_FF_FF, 0, '0, '0, 1'b0);
        add_row(48'hC2_41_00_00_00_00, 1, CP_ERROR, USED_ERROR, 1'b1);
        // three bytes
        add_row(48'hE0_80_80_00_00_00, 1, CP_ERROR, USED_ERROR, 1'b1);
        add_row(48'hE0_A0_80_00_00_00, 1, 16'h0800, USED_LEN3, 1'b0);
        add_row(48'hEF_BF_BF_00_00_00, 1, 16'hFFFF, USED_LEN3, 1'b0);
        add_row(48'hE2_82_AC_7F_00_FF, 0, '0, '0, 1'b0);
        add_row(48'hE2_C2_AC_00_00_00, 1, CP_ERROR, USED_ERROR, 1'b1);
        // four to six bytes: wide values wrap to 16 bits
        add_row(48'hF0_80_80_80_00_00, 1, CP_ERROR, USED_ERROR, 1'b1);
        add_row(48'hF0_90_80_80_00_00, 1, 16'h0000, USED_LEN4, 1'b0);
        add_row(48'hF4_8F_BF_BF_00_00, 1, 16'hFFFF, USED_LEN4, 1'b0);
        add_row(48'hF7_BF_BF_BF_FF_FF, 0, '0, '0, 1'b0);
        add_row(48'hF8_87_BF_BF_BF_00, 1, CP_ERROR, USED_ERROR, 1'b1);
        add_row(48'hF8_88_80_80_80_00, 1, 16'h0000, USED_LEN5, 1'b0);
        add_row(48'hFC_83_BF_BF_BF_BF, 1, CP_ERROR, USED_ERROR, 1'b1);
        add_row(48'hFC_84_80_80_80_80, 1, 16'h0000, USED_LEN6, 1'b0);
        add_row(48'hFD_BF_BF_BF_BF_BF, 1, 16'hFFFF, USED_LEN6, 1'b0);
        add_row(48'hFD_BF_BF_BF_BF_7F, 1, CP_ERROR, USED_ERROR, 1'b1);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            want = dir_rows[i].known ? dir_rows[i].result : decode_window(dir_rows[i].window);
            send_window(dir_rows[i].window, want);
        end
        drain_results();

        for (int i = 0; i < RANDOM_WINDOWS; i++)
        begin
            // idle in bursty phases, then run clean at the tail
            idle_on = (i < RANDOM_WINDOWS - QUIET_TAIL) && ((i / 128) % 3 != 2);
            if (i == RANDOM_WINDOWS / 2)
                drain_results();
            w = make_window();
            send_window(w, decode_window(w));
        end
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Decoded %0d windows (%0d rejected) covering lengths %b of 6..1,",
                 windows_sent, rejects_expected, lengths_seen);
        $display("with random idle on both channels; %0d characters checked.", chars_checked);
        if (mismatches == 0 && pending_chars.size() == 0)
            $display("[utf8_window_decoder] OK");
        else
            $display("[utf8_window_decoder] ERROR");
        $finish;
    end

    // Receiver: stall in short random bursts while idling is on
    initial
    begin
        int stall;
        out_ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                stall = $urandom_range(1, 3);
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_chars
        u8wd_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_chars.size() == 0)
            begin
                $display("%0t: unexpected transfer: code_point %h bytes_used %0d bad_sequence %b",
                         $time, code_point, bytes_used, bad_sequence);
                mismatches++;
            end
            else
            begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (code_point !== want.code_point)
                begin
                    $display("%0t: code_point mismatch: expected %h, actual %h",
                             $time, want.code_point, code_point);
                    mismatches++;
                end
                if (bytes_used !== want.bytes_used)
                begin
                    $display("%0t: bytes_used mismatch: expected %0d, actual %0d",
                             $time, want.bytes_used, bytes_used);
                    mismatches++;
                end
                if (bad_sequence !== want.bad_sequence)
                begin
                    $display("%0t: bad_sequence mismatch: expected %b, actual %b",
                             $time, want.bad_sequence, bad_sequence);
                    mismatches++;
                end
            end
        end
    end

    // Count cycles with no transfer on either channel
    initial
        idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d characters outstanding",
                     $time, idle_cycles, pending_chars.size());
            $display("[utf8_window_decoder] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

// ----- filelist.f -----
hw/rtl/u8wd_pkg.sv
hw/rtl/u8wd_decode.sv
hw/rtl/utf8_window_decoder.sv
test/tb_utf8_window_decoder.sv
